[hw/rtl/move_to_front_coder_defines.svh]
`ifndef MOVE_TO_FRONT_CODER_DEFINES_SVH
`define MOVE_TO_FRONT_CODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("move_to_front_coder assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MTF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("move_to_front_coder assertion failed");

`endif

[hw/rtl/mtf_pkg.sv]
package mtf_pkg;

    localparam int SYM_W = 8;
    localparam int CFG_W = 32;
    localparam int ADDR_W = 3;

    localparam logic REG_DIRECTION = 1'b0;
    localparam logic REG_BLOCK_LEN = 1'b1;

    localparam logic DIR_FORWARD = 1'b0;
    localparam logic DIR_INVERSE = 1'b1;

    typedef struct packed {
        logic             vld;
        logic             found;
        logic [SYM_W-1:0] key;
        logic [SYM_W-1:0] carry;
        logic [SYM_W-1:0] res;
    } t_tok;

    typedef struct packed {
        logic             clr;
        logic             dir;
        logic             ld;
        logic [SYM_W-1:0] ld_val;
    } t_cell_ctl;

endpackage

[hw/rtl/mtf_in_if.sv]
interface mtf_in_if import mtf_pkg::*;;
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] in_value;
    logic             start_new;

    modport source (output valid, output in_value, output start_new, input ready);
    modport sink (input valid, input in_value, input start_new, output ready);
endinterface

[hw/rtl/mtf_out_if.sv]
interface mtf_out_if import mtf_pkg::*;;
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] out_value;

    modport source (output valid, output out_value, input ready);
    modport sink (input valid, input out_value, output ready);
endinterface

[hw/rtl/mtf_cell.sv]
module mtf_cell import mtf_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_tok      i_tok,
    output t_tok      o_tok
);

    localparam logic [SYM_W-1:0] IDX_SYM = SYM_W'(IDX);
    localparam logic IS_HEAD = (IDX == 0);

    logic [SYM_W-1:0] r_sym;
    logic [SYM_W-1:0] n_sym;
    t_tok             r_tok;
    t_tok             n_tok;
    logic             w_match;

    always_comb begin
        w_match = (i_ctl.dir == DIR_INVERSE) ? (i_tok.key == IDX_SYM) : (r_sym == i_tok.key);
        n_sym = r_sym;
        n_tok = i_tok;
        if (i_ctl.clr) begin
            n_sym = IDX_SYM;
        end else if (i_ctl.ld) begin
            n_sym = i_ctl.ld_val;
        end else if (i_tok.vld && !i_tok.found) begin
            // The head keeps its entry when the word already sits at rank zero.
            if (!w_match || !IS_HEAD) begin
                n_sym = i_tok.carry;
            end
            if (w_match) begin
                n_tok.found = 1'b1;
                n_tok.res = (i_ctl.dir == DIR_INVERSE) ? r_sym : IDX_SYM;
            end else begin
                n_tok.carry = r_sym;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym <= IDX_SYM;
            r_tok.vld <= 1'b0;
        end else begin
            r_sym <= n_sym;
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

[hw/rtl/move_to_front_coder.sv]
// An accepted word passes the entry register, then the chain of ALPHABET list cells,
// and its result is then registered at the output. Each word walks the chain one cell
// per cycle, and the next word is taken only once it has left the last cell.
// Reset is synchronous and active low; the list returns to identity order, the block
// count and both registers clear, and no word is in flight.
`include "move_to_front_coder_defines.svh"

module move_to_front_coder import mtf_pkg::*; #(
    parameter int ALPHABET = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mtf_in_if.sink            i_in,
    mtf_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]  prdata,
    output logic              pready
);

    localparam logic [SYM_W:0]   ALPHA_EXT = (SYM_W + 1)'(ALPHABET);
    localparam logic [SYM_W-1:0] MAX_SYM = SYM_W'(ALPHABET - 1);

    logic             r_dir;
    logic [CFG_W-1:0] r_block_len;
    logic [CFG_W-1:0] r_block_count;
    logic [CFG_W-1:0] n_block_count;
    logic             r_busy;
    t_tok             r_entry;
    t_tok             n_entry;
    logic             r_out_vld;
    logic [SYM_W-1:0] r_out_val;
    logic             r_skid_vld;
    logic [SYM_W-1:0] r_skid_val;

    logic             w_accept;
    logic             w_clr;
    logic [SYM_W-1:0] w_key;
    logic             w_fin;
    logic [SYM_W-1:0] w_fin_sym;
    logic             w_out_take;
    logic             w_cfg_wr;
    t_tok             w_tok [ALPHABET+1];

    assign i_in.ready = !r_busy && !r_skid_vld;
    assign w_accept = i_in.valid && i_in.ready;
    assign w_clr = w_accept && (i_in.start_new ||
                   ((r_block_len != '0) && (r_block_count >= r_block_len)));
    assign w_key = ({1'b0, i_in.in_value} >= ALPHA_EXT) ? MAX_SYM : i_in.in_value;

    always_comb begin
        n_entry = r_entry;
        n_entry.vld = w_accept;
        n_entry.found = 1'b0;
        n_entry.key = w_key;
        n_entry.carry = w_key;
        n_entry.res = '0;
        n_block_count = r_block_count;
        if (w_accept) begin
            n_block_count = w_clr ? CFG_W'(1) : r_block_count + CFG_W'(1);
        end
    end

    assign w_tok[0] = r_entry;
    assign w_fin = w_tok[ALPHABET].vld;
    assign w_fin_sym = (r_dir == DIR_INVERSE) ? w_tok[ALPHABET].res : w_tok[ALPHABET].key;

    for (genvar g = 0; g < ALPHABET; g++) begin : g_cell
        t_cell_ctl w_ctl;
        assign w_ctl.clr = w_clr;
        assign w_ctl.dir = r_dir;
        assign w_ctl.ld = (g == 0) ? w_fin : 1'b0;
        assign w_ctl.ld_val = w_fin_sym;

        mtf_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign w_out_take = r_out_vld && o_out.ready;
    assign o_out.valid = r_out_vld;
    assign o_out.out_value = r_out_val;

    assign w_cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BLOCK_LEN) ? r_block_len : {{(CFG_W-1){1'b0}}, r_dir};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= DIR_FORWARD;
            r_block_len <= '0;
            r_block_count <= '0;
            r_busy <= 1'b0;
            r_entry.vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                unique case (paddr[2])
                    REG_DIRECTION: r_dir <= pwdata[0];
                    REG_BLOCK_LEN: r_block_len <= pwdata;
                    default: r_dir <= r_dir;
                endcase
            end
            r_block_count <= n_block_count;
            r_entry <= n_entry;
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_fin) begin
                r_busy <= 1'b0;
            end
            if (w_fin) begin
                if (!r_out_vld || w_out_take) begin
                    r_out_vld <= 1'b1;
                    r_out_val <= w_tok[ALPHABET].res;
                end else begin
                    r_skid_vld <= 1'b1;
                    r_skid_val <= w_tok[ALPHABET].res;
                end
            end else if (w_out_take) begin
                if (r_skid_vld) begin
                    r_out_val <= r_skid_val;
                    r_skid_vld <= 1'b0;
                end else begin
                    r_out_vld <= 1'b0;
                end
            end
        end
    end

    `MTF_ASSERT_NOW(a_fin_found, i_clk, i_rst_n, w_fin, w_tok[ALPHABET].found)
    `MTF_ASSERT_NOW(a_skid_free, i_clk, i_rst_n, w_fin, !r_skid_vld)
    `MTF_ASSERT_NXT(a_busy_set, i_clk, i_rst_n, w_accept, r_busy && r_entry.vld)
    `MTF_ASSERT_NXT(a_busy_clr, i_clk, i_rst_n, w_fin, !r_busy)

endmodule
